// File: hdl/gag_pkg.sv
package gag_pkg;

  // population and gene store sizes
  localparam int unsigned POP_MAX     = 128;
  localparam int unsigned GENES_MAX   = 32;
  localparam int unsigned ALLELE_BITS = 4;

  // request codes
  localparam logic [1:0] REQ_WR_POP   = 2'd0;
  localparam logic [1:0] REQ_WR_MODEL = 2'd1;
  localparam logic [1:0] REQ_RD_POP   = 2'd2;
  localparam logic [1:0] REQ_STEP     = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_ACCESS  = 2'd0;
  localparam logic [1:0] OUT_NEWGEN  = 2'd1;
  localparam logic [1:0] OUT_PERFECT = 2'd2;
  localparam logic [1:0] OUT_LIMIT   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ORGS   = 3'd0;
  localparam logic [2:0] CFG_GENES  = 3'd1;
  localparam logic [2:0] CFG_ALLELE = 3'd2;
  localparam logic [2:0] CFG_PERIOD = 3'd3;
  localparam logic [2:0] CFG_MAXFIT = 3'd4;
  localparam logic [2:0] CFG_MAXGEN = 3'd5;
  localparam logic [2:0] CFG_SEED   = 3'd6;

  localparam int unsigned GenHardLimit = 1000;

  // shared modulo unit request
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } mod_req_t;

  // xorshift 13,17,5
  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

// File: hdl/genetic_algorithm_generation_core.sv
// Genetic algorithm generation engine.
// Requests enter on start with req_type_i, organism_index_i, gene_index_i
// and allele_value_i; a request is taken at a clock edge with start high and
// busy low. Configuration is written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write it only while the block is idle, which the
// block does not enforce; writing the seed reloads the generator. Each request
// gives one result on read_value_o, outcome_o, generation_o and
// total_fitness_o, marked by done_o for one cycle; the receiver cannot stall.
// A gene or model write answers in the cycle after it is taken and busy stays
// low, so writes can follow back to back; a read passes through S_RD_WAIT
// first (registered memory port). A step scores each organism gene by gene,
// then breeds: every draw is a modulo on the shared divider, each roulette
// pick then scans the organisms in order up to the hit or the last one, each
// gene takes a mutation draw (and an allele draw when it mutates), and the
// children are copied back gene by gene.
// Reset clears control state, total and generation count and loads the seed
// value 1; the gene stores and scores are undefined until written.
module genetic_algorithm_generation_core
  import gag_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  organism_index_i,
  input  logic [4:0]  gene_index_i,
  input  logic [3:0]  allele_value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [3:0]  read_value_o,
  output logic [1:0]  outcome_o,
  output logic [9:0]  generation_o,
  output logic [12:0] total_fitness_o
);

  localparam int unsigned OB = $clog2(POP_MAX);
  localparam int unsigned GB = (GENES_MAX > 1) ? $clog2(GENES_MAX) : 1;
  localparam int unsigned AB = OB + GB;
  localparam int unsigned DEPTH = POP_MAX * GENES_MAX;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_SC_RD, S_SC_ACC, S_SC_ORG, S_PERF, S_DECIDE,
    S_PICK_MOD, S_PICK_WAIT, S_PICK_RD, S_PICK_SCAN, S_CUT_MOD, S_CUT_WAIT,
    S_MUT_MOD, S_MUT_WAIT, S_ALL_MOD, S_ALL_WAIT, S_CP_RD, S_CP_WR,
    S_SWAP_RD, S_SWAP_WAIT, S_SWAP_WR, S_FINISH
  } state_e;

  // configuration
  logic [7:0]  orgs_cfg_q;
  logic [5:0]  genes_cfg_q;
  logic [4:0]  allele_cfg_q;
  logic [15:0] period_cfg_q;
  logic [5:0]  maxfit_q;
  logic [9:0]  maxgen_q;

  state_e      state_q;
  logic [31:0] rng_q;
  logic [9:0]  gen_q;
  logic [12:0] total_q;
  logic        done_q;
  logic [3:0]  rdv_q;
  logic [1:0]  outc_q;

  logic [OB-1:0] org_q, p1_q, p2_q;
  logic [GB-1:0] gene_q, cut_q;
  logic [5:0]    fit_q;
  logic [12:0]   sum_q;
  logic          second_q, perf_q, mut_q;
  logic [OB-1:0] scan_q;
  logic [15:0]   r_q;
  logic [3:0]    gval_q;

  // clamped settings
  logic [OB:0]   orgs_c;
  logic [GB:0]   genes_c;
  logic [15:0]   alleles_c, period_c;
  always_comb begin
    if (orgs_cfg_q == 8'd0) orgs_c = (OB+1)'(1);
    else if (32'(orgs_cfg_q) > POP_MAX) orgs_c = (OB+1)'(POP_MAX);
    else orgs_c = (OB+1)'(orgs_cfg_q);
    if (genes_cfg_q == 6'd0) genes_c = (GB+1)'(1);
    else if (32'(genes_cfg_q) > GENES_MAX) genes_c = (GB+1)'(GENES_MAX);
    else genes_c = (GB+1)'(genes_cfg_q);
    if (allele_cfg_q == 5'd0) alleles_c = 16'd1;
    else if (32'(allele_cfg_q) > (1 << ALLELE_BITS)) alleles_c = 16'(1 << ALLELE_BITS);
    else alleles_c = 16'(allele_cfg_q);
    period_c = (period_cfg_q == 16'd0) ? 16'd1 : period_cfg_q;
  end

  // memories: population, children, model
  logic [3:0] pop_mem [DEPTH];
  logic [3:0] chd_mem [DEPTH];
  logic [3:0] model_mem [GENES_MAX];
  logic [3:0] pop_rd_q, chd_rd_q, model_rd_q;
  logic          pop_we, chd_we;
  logic [AB-1:0] pop_wa, pop_ra, chd_wa, chd_ra;
  logic [3:0]    pop_wd, chd_wd;
  logic [GB-1:0] model_ra;

  always_ff @(posedge clk_i) begin
    if (pop_we) pop_mem[pop_wa] <= pop_wd;
    pop_rd_q <= pop_mem[pop_ra];
    if (chd_we) chd_mem[chd_wa] <= chd_wd;
    chd_rd_q <= chd_mem[chd_ra];
    if (start && !busy && req_type_i == REQ_WR_MODEL && 32'(gene_index_i) < GENES_MAX)
      model_mem[GB'(gene_index_i)] <= allele_value_i;
    model_rd_q <= model_mem[model_ra];
  end

  // score store, written while scoring and read by the roulette scan
  logic [5:0] scores_mem [POP_MAX];
  logic [5:0] sc_rd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SC_ORG) scores_mem[org_q] <= fit_q;
    sc_rd_q <= scores_mem[scan_q];
  end

  // shared modulo unit
  mod_req_t    mreq;
  logic        mdone;
  logic [15:0] mrem;
  gag_mod_unit u_mod (.clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .rem_o(mrem));

  logic [31:0] rng_nx;
  assign rng_nx = xorshift(rng_q);

  logic addr_ok;
  assign addr_ok = 32'(organism_index_i) < POP_MAX && 32'(gene_index_i) < GENES_MAX;
  logic [AB-1:0] in_addr;
  assign in_addr = {OB'(organism_index_i), GB'(gene_index_i)};

  logic [12:0] scan_sum;
  assign scan_sum = sum_q + 13'(sc_rd_q);

  // memory port steering
  always_comb begin
    pop_we   = 1'b0;
    pop_wa   = in_addr;
    pop_wd   = allele_value_i;
    pop_ra   = in_addr;
    chd_we   = 1'b0;
    chd_wa   = {org_q, gene_q};
    chd_wd   = gval_q;
    chd_ra   = {org_q, gene_q};
    model_ra = gene_q;
    if (state_q == S_IDLE) begin
      pop_we = start && req_type_i == REQ_WR_POP && addr_ok;
    end else if (state_q == S_SC_RD) begin
      pop_ra = {org_q, gene_q};
    end else if (state_q == S_CP_RD || state_q == S_MUT_MOD) begin
      pop_ra = {(gene_q < cut_q) ? p1_q : p2_q, gene_q};
    end else if (state_q == S_CP_WR) begin
      chd_we = 1'b1;
      chd_wd = mut_q ? gval_q : pop_rd_q;
    end else if (state_q == S_SWAP_WR) begin
      pop_we = 1'b1;
      pop_wa = {org_q, gene_q};
      pop_wd = chd_rd_q;
    end
  end

  // modulo requests
  always_comb begin
    mreq.start    = 1'b0;
    mreq.dividend = rng_nx;
    mreq.divisor  = period_c;
    case (state_q)
      S_PICK_MOD: begin
        mreq.start = 1'b1;
        mreq.divisor = 16'(total_q) + 16'd1;
      end
      S_CUT_MOD: begin
        mreq.start = 1'b1;
        mreq.divisor = 16'(genes_c);
      end
      S_MUT_MOD: mreq.start = 1'b1;
      S_ALL_MOD: begin
        mreq.start = 1'b1;
        mreq.divisor = alleles_c;
      end
      default: ;
    endcase
  end

  logic last_gene, last_org;
  assign last_gene = ({1'b0, gene_q} == genes_c - (GB+1)'(1));
  assign last_org  = ({1'b0, org_q} == orgs_c - (OB+1)'(1));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      orgs_cfg_q <= 8'd100; genes_cfg_q <= 6'd20; allele_cfg_q <= 5'd4;
      period_cfg_q <= 16'd1000; maxfit_q <= 6'd20; maxgen_q <= 10'd1000;
      rng_q <= 32'd1; gen_q <= '0; total_q <= '0;
      done_q <= 1'b0; rdv_q <= '0; outc_q <= OUT_ACCESS;
      org_q <= '0; p1_q <= '0; p2_q <= '0; gene_q <= '0; cut_q <= '0;
      fit_q <= '0; sum_q <= '0; second_q <= 1'b0; perf_q <= 1'b0; scan_q <= '0;
      r_q <= '0; gval_q <= '0; mut_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ORGS:   orgs_cfg_q <= cfg_data_i[7:0];
          CFG_GENES:  genes_cfg_q <= cfg_data_i[5:0];
          CFG_ALLELE: allele_cfg_q <= cfg_data_i[4:0];
          CFG_PERIOD: period_cfg_q <= cfg_data_i[15:0];
          CFG_MAXFIT: maxfit_q <= cfg_data_i[5:0];
          CFG_MAXGEN: maxgen_q <= cfg_data_i[9:0];
          CFG_SEED:   rng_q <= (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (start) begin
          rdv_q <= '0;
          outc_q <= OUT_ACCESS;
          case (req_type_i)
            REQ_RD_POP: state_q <= S_RD_WAIT;
            REQ_STEP: begin
              org_q <= '0; gene_q <= '0; fit_q <= '0; sum_q <= '0; perf_q <= 1'b0;
              state_q <= S_SC_RD;
            end
            default: done_q <= 1'b1;
          endcase
          second_q <= addr_ok;
        end
        // read data taken at acceptance is on the memory output now
        S_RD_WAIT: begin
          rdv_q <= second_q ? pop_rd_q : 4'd0;
          done_q <= 1'b1;
          state_q <= S_IDLE;
        end
        // scoring: memory reads of gene and model land next cycle
        S_SC_RD: state_q <= S_SC_ACC;
        S_SC_ACC: begin
          if (pop_rd_q == model_rd_q) fit_q <= fit_q + 6'd1;
          if (last_gene) state_q <= S_SC_ORG;
          else begin
            gene_q <= gene_q + GB'(1);
            state_q <= S_SC_RD;
          end
        end
        S_SC_ORG: begin
          sum_q <= sum_q + 13'(fit_q);
          if (fit_q == maxfit_q) perf_q <= 1'b1;
          fit_q <= '0;
          gene_q <= '0;
          if (last_org) state_q <= S_PERF;
          else begin
            org_q <= org_q + OB'(1);
            state_q <= S_SC_RD;
          end
        end
        S_PERF: begin
          total_q <= sum_q;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (perf_q) begin
            outc_q <= OUT_PERFECT; done_q <= 1'b1; state_q <= S_IDLE;
          end else if (11'(gen_q) + 11'd1 >= 11'(maxgen_q) ||
                       11'(gen_q) + 11'd1 >= 11'(GenHardLimit)) begin
            outc_q <= OUT_LIMIT; done_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            org_q <= '0; second_q <= 1'b0; state_q <= S_PICK_MOD;
          end
        end
        // roulette pick
        S_PICK_MOD: begin
          rng_q <= rng_nx; state_q <= S_PICK_WAIT;
        end
        S_PICK_WAIT: if (mdone) begin
          r_q <= mrem; sum_q <= '0; scan_q <= '0;
          state_q <= S_PICK_RD;
        end
        // score of the scanned organism lands next cycle
        S_PICK_RD: state_q <= S_PICK_SCAN;
        S_PICK_SCAN: begin
          logic hit, end_s;
          hit   = 16'(scan_sum) >= r_q;
          end_s = ({1'b0, scan_q} == orgs_c - (OB+1)'(1));
          sum_q <= scan_sum;
          if (hit || end_s) begin
            if (!second_q) begin
              p1_q <= hit ? scan_q : '0;
              second_q <= 1'b1;
              state_q <= S_PICK_MOD;
            end else begin
              p2_q <= hit ? scan_q : '0;
              second_q <= 1'b0;
              state_q <= S_CUT_MOD;
            end
          end else begin
            scan_q <= scan_q + OB'(1);
            state_q <= S_PICK_RD;
          end
        end
        S_CUT_MOD: begin
          rng_q <= rng_nx; state_q <= S_CUT_WAIT;
        end
        S_CUT_WAIT: if (mdone) begin
          cut_q <= GB'(mrem); gene_q <= '0; state_q <= S_MUT_MOD;
        end
        // per gene mutation or copy
        S_MUT_MOD: begin
          rng_q <= rng_nx; state_q <= S_MUT_WAIT;
        end
        S_MUT_WAIT: if (mdone) begin
          mut_q <= (mrem == 16'd0);
          state_q <= (mrem == 16'd0) ? S_ALL_MOD : S_CP_RD;
        end
        S_ALL_MOD: begin
          rng_q <= rng_nx; state_q <= S_ALL_WAIT;
        end
        S_ALL_WAIT: if (mdone) begin
          gval_q <= mrem[3:0]; state_q <= S_CP_WR;
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          if (last_gene) begin
            gene_q <= '0;
            if (last_org) begin
              org_q <= '0; state_q <= S_SWAP_RD;
            end else begin
              org_q <= org_q + OB'(1); state_q <= S_PICK_MOD;
            end
          end else begin
            gene_q <= gene_q + GB'(1); state_q <= S_MUT_MOD;
          end
        end
        // children replace population
        S_SWAP_RD: state_q <= S_SWAP_WAIT;
        S_SWAP_WAIT: state_q <= S_SWAP_WR;
        S_SWAP_WR: begin
          if (last_gene) begin
            gene_q <= '0;
            if (last_org) state_q <= S_FINISH;
            else begin
              org_q <= org_q + OB'(1); state_q <= S_SWAP_RD;
            end
          end else begin
            gene_q <= gene_q + GB'(1); state_q <= S_SWAP_RD;
          end
        end
        S_FINISH: begin
          gen_q <= gen_q + 10'd1;
          outc_q <= OUT_NEWGEN; done_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign read_value_o    = rdv_q;
  assign outcome_o       = outc_q;
  assign generation_o    = gen_q;
  assign total_fitness_o = total_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result outside idle");
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && outc_q != OUT_ACCESS |-> rdv_q == 4'd0) else $error("read value on step");
  a_gen_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q < 10'(GenHardLimit)) else $error("generation over limit");

endmodule

// File: hdl/gag_mod_unit.sv
module gag_mod_unit
  import gag_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mod_req_t    req_i,
  output logic        done_o,
  output logic [15:0] rem_o
);

  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;

  // one restoring step per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], quo_q[31]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_d = trial - {1'b0, div_q};
      else rem_d = trial;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[15:0];

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("modulo done held");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && div_q != 16'd0 |-> rem_q < {1'b0, div_q}) else $error("remainder out of range");
  a_no_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");

endmodule

// File: bench/genetic_algorithm_generation_core_tb.sv
module genetic_algorithm_generation_core_tb;
  import gag_pkg::*;

  typedef struct {
    logic [3:0]  rd;
    logic [1:0]  oc;
    logic [9:0]  gen;
    logic [12:0] tf;
  } gene_result_t;

  // predictor of the generation engine and store of pending results
  class gene_scoreboard;
    logic [3:0]  pop_genes [4096];
    logic [3:0]  kid_genes [4096];
    logic [3:0]  target_genes [32];
    logic [5:0]  org_score [128];
    logic [12:0] fit_total;
    logic [9:0]  gen_count;
    logic [31:0] rng;
    logic [7:0]  r_orgs;
    logic [5:0]  r_genes;
    logic [4:0]  r_alleles;
    logic [15:0] r_period;
    logic [5:0]  r_maxfit;
    logic [9:0]  r_maxgen;
    logic [31:0] r_seed;
    gene_result_t result_q[$];
    int errors, n_new, n_perfect, n_limit, n_access;

    function new();
      foreach (pop_genes[i]) pop_genes[i] = '0;
      foreach (kid_genes[i]) kid_genes[i] = '0;
      foreach (target_genes[i]) target_genes[i] = '0;
      foreach (org_score[i]) org_score[i] = '0;
      fit_total = '0;
      gen_count = '0;
      r_orgs = 8'd100;
      r_genes = 6'd20;
      r_alleles = 5'd4;
      r_period = 16'd1000;
      r_maxfit = 6'd20;
      r_maxgen = 10'd1000;
      r_seed = 32'd1;
      rng = 32'd1;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
        CFG_ORGS:   r_orgs = data[7:0];
        CFG_GENES:  r_genes = data[5:0];
        CFG_ALLELE: r_alleles = data[4:0];
        CFG_PERIOD: r_period = data[15:0];
        CFG_MAXFIT: r_maxfit = data[5:0];
        CFG_MAXGEN: r_maxgen = data[9:0];
        CFG_SEED: begin
          r_seed = data;
          rng = (data == 0) ? 32'd1 : data;
        end
        default: ;
      endcase
    endfunction

    // xorshift 13,17,5
    function logic [31:0] next_draw();
      logic [31:0] x;
      x = rng;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rng = x;
      return x;
    endfunction

    // roulette wheel over the organisms in use
    function int unsigned pick_parent(input int unsigned orgs);
      int unsigned r, sum, tot;
      tot = fit_total;
      r = next_draw() % (tot + 1);
      sum = 0;
      for (int unsigned i = 0; i < orgs; i++) begin
        sum += org_score[i];
        if (sum >= r) return i;
      end
      return 0;
    endfunction

    function logic [1:0] run_generation();
      int unsigned orgs, genes, alleles, period, tot, fit, p1, p2, cut, gc;
      logic [3:0] g;
      bit perfect;
      orgs = (r_orgs < 1) ? 1 : ((r_orgs > 128) ? 128 : r_orgs);
      genes = (r_genes < 1) ? 1 : ((r_genes > 32) ? 32 : r_genes);
      alleles = (r_alleles < 1) ? 1 : ((r_alleles > 16) ? 16 : r_alleles);
      period = (r_period == 0) ? 1 : r_period;
      perfect = 0;
      // scoring pass
      tot = 0;
      for (int unsigned i = 0; i < orgs; i++) begin
        fit = 0;
        for (int unsigned j = 0; j < genes; j++)
          if (pop_genes[i*32+j] == target_genes[j]) fit++;
        org_score[i] = fit[5:0];
        tot += fit;
      end
      fit_total = tot[12:0];
      for (int unsigned i = 0; i < orgs; i++)
        if (org_score[i] == r_maxfit) perfect = 1;
      if (perfect) return OUT_PERFECT;
      gc = gen_count;
      if (gc + 1 >= r_maxgen || gc + 1 >= 1000) return OUT_LIMIT;
      // breeding pass
      for (int unsigned i = 0; i < orgs; i++) begin
        p1 = pick_parent(orgs);
        p2 = pick_parent(orgs);
        cut = next_draw() % genes;
        for (int unsigned j = 0; j < genes; j++) begin
          if (next_draw() % period == 0) g = 4'(next_draw() % alleles);
          else if (j < cut) g = pop_genes[p1*32+j];
          else g = pop_genes[p2*32+j];
          kid_genes[i*32+j] = g;
        end
      end
      for (int unsigned i = 0; i < orgs; i++)
        for (int unsigned j = 0; j < genes; j++)
          pop_genes[i*32+j] = kid_genes[i*32+j];
      gen_count = gen_count + 10'd1;
      return OUT_NEWGEN;
    endfunction

    function void note_request(input logic [1:0] rq, input logic [6:0] org,
                               input logic [4:0] gene, input logic [3:0] val);
      gene_result_t r;
      r.rd = '0;
      r.oc = OUT_ACCESS;
      case (rq)
        REQ_WR_POP:   pop_genes[{org, gene}] = val;
        REQ_WR_MODEL: target_genes[gene] = val;
        REQ_RD_POP:   r.rd = pop_genes[{org, gene}];
        default:      r.oc = run_generation();
      endcase
      r.gen = gen_count;
      r.tf = fit_total;
      result_q.push_back(r);
    endfunction

    task check_result(input logic [3:0] rd, input logic [1:0] oc,
                      input logic [9:0] gen, input logic [12:0] tf);
      gene_result_t e;
      if (result_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        e = result_q.pop_front();
        case (e.oc)
          OUT_NEWGEN:  n_new++;
          OUT_PERFECT: n_perfect++;
          OUT_LIMIT:   n_limit++;
          default:     n_access++;
        endcase
        if (rd !== e.rd) report($sformatf("read_value %0h, want %0h", rd, e.rd));
        if (oc !== e.oc) report($sformatf("outcome %0d, want %0d", oc, e.oc));
        if (gen !== e.gen) report($sformatf("generation %0d, want %0d", gen, e.gen));
        if (tf !== e.tf) report($sformatf("total_fitness %0d, want %0d", tf, e.tf));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [6:0]  organism_index_i = '0;
  logic [4:0]  gene_index_i = '0;
  logic [3:0]  allele_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic [3:0]  read_value_o;
  logic [1:0]  outcome_o;
  logic [9:0]  generation_o;
  logic [12:0] total_fitness_o;

  gene_scoreboard sb;
  int burst_left = 0;

  genetic_algorithm_generation_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .organism_index_i, .gene_index_i,
    .allele_value_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .done_o, .read_value_o,
    .outcome_o, .generation_o, .total_fitness_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o && sb != null)
      sb.check_result(read_value_o, outcome_o, generation_o, total_fitness_o);
  end

  // one request, with a random gap at the start of each burst
  task automatic send_request(input logic [1:0] rq, input logic [6:0] org,
                              input logic [4:0] gene, input logic [3:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= rq;
    organism_index_i <= org;
    gene_index_i <= gene;
    allele_value_i <= val;
    do @(posedge clk_i); while (busy);
    sb.note_request(rq, org, gene, val);
  endtask

  // lower start, then wait until every request has answered
  task automatic settle();
    start <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // write all registers, junk above each register width
  task automatic set_regs(input int unsigned orgs, input int unsigned genes,
                          input int unsigned alleles, input int unsigned period,
                          input int unsigned maxfit, input int unsigned maxgen,
                          input logic [31:0] seed);
    logic [31:0] vals [7];
    int widths [7];
    logic [31:0] d;
    vals = '{orgs, genes, alleles, period, maxfit, maxgen, seed};
    widths = '{8, 6, 5, 16, 6, 10, 32};
    for (int i = 0; i < 7; i++) begin
      d = vals[i];
      if (widths[i] < 32) d = (vals[i] & ((32'd1 << widths[i]) - 1)) | ($urandom << widths[i]);
      cfg_we_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i <= d;
      @(posedge clk_i);
      sb.write_reg(3'(i), d);
    end
    cfg_we_i <= 1'b0;
  endtask

  // reads stay inside the filled region of six organisms by eight genes
  task automatic random_request();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) send_request(REQ_STEP, 7'($urandom), 5'($urandom), 4'($urandom));
    else if (k < 60) send_request(REQ_WR_POP, 7'($urandom), 5'($urandom), 4'($urandom));
    else if (k < 75) send_request(REQ_WR_MODEL, 7'($urandom), 5'($urandom), 4'($urandom));
    else send_request(REQ_RD_POP, 7'($urandom_range(0, 5)), 5'($urandom_range(0, 7)),
                      4'($urandom));
  endtask

  initial begin
    int genes, maxfit, period;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the region used by the steps so nothing unwritten is ever read
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 8; j++)
        send_request(REQ_WR_POP, 7'(i), 5'(j), 4'($urandom));
    for (int j = 0; j < 8; j++) send_request(REQ_WR_MODEL, 7'($urandom), 5'(j), 4'($urandom));
    settle();

    // directed: perfect organism, extremes of the fields, rescoring
    set_regs(4, 4, 16, 1000, 4, 1000, $urandom);
    send_request(REQ_WR_MODEL, 7'd0, 5'd0, 4'd15);
    send_request(REQ_WR_MODEL, 7'd127, 5'd1, 4'd0);
    send_request(REQ_WR_MODEL, 7'd0, 5'd2, 4'd15);
    send_request(REQ_WR_MODEL, 7'd0, 5'd3, 4'd0);
    send_request(REQ_WR_POP, 7'd0, 5'd0, 4'd15);
    send_request(REQ_WR_POP, 7'd0, 5'd1, 4'd0);
    send_request(REQ_WR_POP, 7'd0, 5'd2, 4'd15);
    send_request(REQ_WR_POP, 7'd0, 5'd3, 4'd0);
    send_request(REQ_WR_POP, 7'd127, 5'd31, 4'd15);
    send_request(REQ_RD_POP, 7'd127, 5'd31, 4'd0);
    send_request(REQ_RD_POP, 7'd0, 5'd0, 4'd0);
    send_request(REQ_STEP, 7'd0, 5'd0, 4'd0);
    send_request(REQ_STEP, 7'd127, 5'd31, 4'd15);
    settle();
    // generation limit of one, then a stopped population rescored
    set_regs(4, 4, 16, 1000, 63, 1, $urandom);
    send_request(REQ_STEP, 7'd5, 5'd5, 4'd5);
    send_request(REQ_STEP, 7'd9, 5'd9, 4'd9);
    settle();
    // zero seed, zero period, zero sizes (clamped up)
    set_regs(0, 0, 0, 0, 63, 1000, 32'd0);
    send_request(REQ_STEP, 7'd0, 5'd0, 4'd0);
    send_request(REQ_RD_POP, 7'd0, 5'd0, 4'd0);
    settle();
    set_regs(6, 5, 3, 1, 63, 1000, 32'hFFFF_FFFF);
    send_request(REQ_STEP, 7'd0, 5'd0, 4'd0);
    settle();
    // oversized allele count clamped down, widest period, zero limit
    set_regs(6, 8, 31, 65535, 63, 0, $urandom);
    send_request(REQ_STEP, 7'd0, 5'd0, 4'd0);
    settle();
    set_regs(6, 8, 16, 65535, 63, 1000, $urandom);
    send_request(REQ_STEP, 7'd0, 5'd0, 4'd0);
    settle();

    // random phases on small populations
    for (int ph = 0; ph < 4; ph++) begin
      genes = $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: period = 1;
        1: period = $urandom_range(2, 8);
        default: period = $urandom_range(0, 65535);
      endcase
      maxfit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, genes) : 63;
      set_regs($urandom_range(1, 6), genes, $urandom_range(0, 31), period, maxfit,
               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : 1000, $urandom);
      for (int n = 0; n < 8; n++) random_request();
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d accesses, %0d new generations, %0d perfect stops, %0d limit stops",
             sb.n_access, sb.n_new, sb.n_perfect, sb.n_limit);
    $display("final generation count %0d, %0d mismatches", sb.gen_count, sb.errors);
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("[genetic_algorithm_generation_core] OK");
    end else begin
      $display("[genetic_algorithm_generation_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60000000;
    $display("timeout with %0d results outstanding", sb.result_q.size());
    $display("[genetic_algorithm_generation_core] ERROR");
    $finish;
  end

endmodule
